// ===== hdl/clnrs_pkg.sv =====
`default_nettype none

package clnrs_pkg;

   localparam int COLUMNS_DEFAULT = 16;
   localparam int ROWS_DEFAULT    = 2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam logic [7:0] SET_ADDR_CMD = 8'h80;
   localparam logic [7:0] BIT_BL       = 8'h08;
   localparam logic [7:0] BIT_EN       = 8'h04;
   localparam logic [7:0] BIT_RS       = 8'h01;
   localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam int         ROW_SHIFT    = 6;

   localparam logic [2:0] PHASE_FIRST   = 3'd0;
   localparam logic [2:0] PHASE_EN_HIGH = 3'd1;
   localparam logic [2:0] PHASE_LOW     = 3'd3;
   localparam logic [2:0] PHASE_EN_LOW  = 3'd4;
   localparam logic [2:0] PHASE_LAST    = 3'd5;

   typedef struct packed {
      logic       command;
      logic       row;
      logic [3:0] column;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       frame_end;
      logic [7:0] frame_count;
   } rsp_type;

   typedef struct packed {
      logic       is_cmd;
      logic       row;
      logic       is_low;
      logic       is_en;
      logic       last;
      logic       written;
      logic [7:0] count;
   } stage_type;

endpackage

`default_nettype wire

// ===== hdl/clnrs_ram.sv =====
`default_nettype none

module clnrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/char_lcd_nibble_refresh_serializer_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  clnrs_pkg::req_type
// rsp_      out        rsp_valid/rsp_stall  clnrs_pkg::rsp_type
// csr_      in         csr_wr_en            backlight_on (1 bit)
//
// A fetch beat reaches rsp through the text store read and then the result register.
// One beat is accepted every cycle while rsp is not stalled.
// A write beat gives no result and updates the store in the cycle after it is accepted.
// Synchronous reset clears the position counters, the frame count, the backlight
// and the written flags, so every character reads as a space until written.
// A stall on rsp holds the result register and stalls req once the read stage is full.

module char_lcd_nibble_refresh_serializer_unit #(
   parameter int COLUMNS = clnrs_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = clnrs_pkg::ROWS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  clnrs_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output clnrs_pkg::rsp_type  rsp_payload,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data
);

   localparam int DEPTH  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(COLUMNS + 1);

   logic                 backlight_ff;
   logic                 row_ff, row_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           frames_ff, frames_in;
   logic [DEPTH-1:0]     written_ff;
   logic                 s1_valid_ff;
   clnrs_pkg::stage_type s1_ff, s1_in;
   logic                 rsp_valid_ff;
   clnrs_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;

   logic              s1_advance, s1_load, accept, fetch, store;
   logic              frame_first;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        ram_data, char_val, nibble_val;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || s1_advance;
   assign req_stall  = !s1_load;
   assign accept     = req_valid && s1_load;
   assign fetch      = accept && (req_payload.command == clnrs_pkg::CMD_FETCH);
   assign store      = accept && (req_payload.command == clnrs_pkg::CMD_WRITE)
                       && (int'(req_payload.row) < ROWS)
                       && (int'(req_payload.column) < COLUMNS);

   assign wr_addr = ADDR_W'(req_payload.row) * ADDR_W'(COLUMNS)
                    + ADDR_W'(req_payload.column);
   assign rd_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(pos_ff - POS_W'(1));

   clnrs_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_text_store (
      .clock  (clock),
      .wr_en  (store),
      .wr_addr(wr_addr),
      .wr_data(req_payload.character),
      .rd_en  (fetch),
      .rd_addr(rd_addr),
      .rd_data(ram_data)
   );

   assign frame_first = (row_ff == 1'b0) && (pos_ff == '0)
                        && (phase_ff == clnrs_pkg::PHASE_FIRST);

   always_comb begin
      row_in    = row_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      frames_in = frames_ff;
      if (fetch) begin
         if (frame_first) begin
            frames_in = frames_ff + 8'd1;
         end
         if (phase_ff == clnrs_pkg::PHASE_LAST) begin
            phase_in = clnrs_pkg::PHASE_FIRST;
            if (pos_ff == POS_W'(COLUMNS)) begin
               pos_in = '0;
               row_in = (row_ff == 1'(ROWS - 1)) ? 1'b0 : 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
   end

   always_comb begin
      s1_in.is_cmd  = (pos_ff == '0);
      s1_in.row     = row_ff;
      s1_in.is_low  = (phase_ff >= clnrs_pkg::PHASE_LOW);
      s1_in.is_en   = (phase_ff == clnrs_pkg::PHASE_EN_HIGH)
                      || (phase_ff == clnrs_pkg::PHASE_EN_LOW);
      s1_in.last    = (row_ff == 1'(ROWS - 1)) && (pos_ff == POS_W'(COLUMNS))
                      && (phase_ff == clnrs_pkg::PHASE_LAST);
      s1_in.written = written_ff[rd_addr];
      s1_in.count   = frames_in;
   end

   always_comb begin
      if (s1_ff.is_cmd) begin
         char_val = clnrs_pkg::SET_ADDR_CMD | (8'(s1_ff.row) << clnrs_pkg::ROW_SHIFT);
      end else if (s1_ff.written) begin
         char_val = ram_data;
      end else begin
         char_val = clnrs_pkg::SPACE_CHAR;
      end
      nibble_val = s1_ff.is_low ? {char_val[3:0], 4'h0} : (char_val & clnrs_pkg::HIGH_NIBBLE);
      rsp_payload_in.expander_byte = nibble_val
         | (s1_ff.is_cmd ? 8'h00 : clnrs_pkg::BIT_RS)
         | (backlight_ff ? clnrs_pkg::BIT_BL : 8'h00)
         | (s1_ff.is_en ? clnrs_pkg::BIT_EN : 8'h00);
      rsp_payload_in.frame_end   = s1_ff.last;
      rsp_payload_in.frame_count = s1_ff.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b0;
         row_ff       <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= clnrs_pkg::PHASE_FIRST;
         frames_ff    <= 8'd0;
         written_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            backlight_ff <= csr_wr_data;
         end
         row_ff    <= row_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         frames_ff <= frames_in;
         if (store) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (s1_load) begin
            s1_valid_ff <= fetch;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         s1_ff <= s1_in;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req stalled while the pipeline has room");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= clnrs_pkg::PHASE_LAST)
      else $error("byte phase out of range");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (fetch && (phase_ff != clnrs_pkg::PHASE_LAST)) |=> (phase_ff == $past(phase_ff) + 3'd1))
      else $error("byte phase did not advance on a fetch");

   a_frame_end_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.frame_end)
      |-> ((rsp_payload_ff.expander_byte & clnrs_pkg::BIT_EN) == 8'h00
           && (rsp_payload_ff.expander_byte & clnrs_pkg::BIT_RS) != 8'h00))
      else $error("last byte of a frame has a wrong strobe or select bit");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int COLUMNS          = clnrs_pkg::COLUMNS_DEFAULT;
   localparam int ROWS             = clnrs_pkg::ROWS_DEFAULT;
   localparam int SLOTS_PER_ROW    = COLUMNS + 1;
   localparam int SLOTS_PER_FRAME  = ROWS * SLOTS_PER_ROW;
   localparam int SETTLE_CYCLES    = 6;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT      = 20000;
   localparam int MAX_REPORTS      = 10;
   localparam int RANDOM_PER_PHASE = 140;

   typedef struct {
      clnrs_pkg::req_type item;
      bit                 typed;
      clnrs_pkg::rsp_type want;
   } table_row_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   clnrs_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   clnrs_pkg::rsp_type rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic               csr_wr_data = 1'b0;

   logic [7:0] shadow_text [ROWS * COLUMNS];
   int         slot_pos         = 0;
   logic [2:0] nib_phase        = clnrs_pkg::PHASE_FIRST;
   logic [7:0] shadow_frames    = 8'd0;
   logic       shadow_backlight = 1'b0;

   clnrs_pkg::rsp_type lcd_expect_q [$];
   table_row_type      directed_rows [$];
   int         mismatches    = 0;
   int         cycle_count   = 0;
   int         req_idle_pct  = 0;
   int         rsp_idle_pct  = 0;
   int         hold_requests = 0;
   int         holds_served  = 0;
   int         hold_left     = 0;

   char_lcd_nibble_refresh_serializer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic clnrs_pkg::rsp_type next_lcd_byte();
      clnrs_pkg::rsp_type r;
      int         text_row;
      int         col_slot;
      logic [7:0] value;
      logic [7:0] sig;
      if (slot_pos == 0 && nib_phase == clnrs_pkg::PHASE_FIRST) begin
         shadow_frames = shadow_frames + 8'd1;
      end
      text_row = slot_pos / SLOTS_PER_ROW;
      col_slot = slot_pos % SLOTS_PER_ROW;
      if (col_slot == 0) begin
         value = clnrs_pkg::SET_ADDR_CMD | 8'(text_row << clnrs_pkg::ROW_SHIFT);
         sig   = 8'h00;
      end else begin
         value = shadow_text[text_row * COLUMNS + col_slot - 1];
         sig   = clnrs_pkg::BIT_RS;
      end
      if (shadow_backlight) begin
         sig = sig | clnrs_pkg::BIT_BL;
      end
      if (nib_phase < clnrs_pkg::PHASE_LOW) begin
         r.expander_byte = (value & clnrs_pkg::HIGH_NIBBLE) | sig;
      end else begin
         r.expander_byte = {value[3:0], 4'h0} | sig;
      end
      if (nib_phase == clnrs_pkg::PHASE_EN_HIGH || nib_phase == clnrs_pkg::PHASE_EN_LOW) begin
         r.expander_byte = r.expander_byte | clnrs_pkg::BIT_EN;
      end
      r.frame_end   = (slot_pos == SLOTS_PER_FRAME - 1) && (nib_phase == clnrs_pkg::PHASE_LAST);
      r.frame_count = shadow_frames;
      if (nib_phase == clnrs_pkg::PHASE_LAST) begin
         nib_phase = clnrs_pkg::PHASE_FIRST;
         slot_pos  = (slot_pos == SLOTS_PER_FRAME - 1) ? 0 : slot_pos + 1;
      end else begin
         nib_phase = nib_phase + 3'd1;
      end
      return r;
   endfunction

   function automatic clnrs_pkg::req_type fetch_item();
      clnrs_pkg::req_type r;
      r           = '0;
      r.command   = clnrs_pkg::CMD_FETCH;
      return r;
   endfunction

   function automatic clnrs_pkg::req_type write_item(input logic row, input logic [3:0] column,
                                                     input logic [7:0] character);
      clnrs_pkg::req_type r;
      r.command   = clnrs_pkg::CMD_WRITE;
      r.row       = row;
      r.column    = column;
      r.character = character;
      return r;
   endfunction

   function automatic clnrs_pkg::req_type random_item(input int write_pct);
      clnrs_pkg::req_type r;
      r.command   = ($urandom_range(99) < write_pct) ? clnrs_pkg::CMD_WRITE
                                                     : clnrs_pkg::CMD_FETCH;
      r.row       = 1'($urandom_range(1));
      r.column    = 4'($urandom_range(15));
      r.character = 8'($urandom_range(255));
      return r;
   endfunction

   task automatic send_beat(input clnrs_pkg::req_type item, input bit typed,
                            input clnrs_pkg::rsp_type want);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.command == clnrs_pkg::CMD_WRITE) begin
         shadow_text[int'(item.row) * COLUMNS + int'(item.column)] = item.character;
      end else if (typed) begin
         void'(next_lcd_byte());
         lcd_expect_q.push_back(want);
      end else begin
         lcd_expect_q.push_back(next_lcd_byte());
      end
   endtask

   task automatic drain_beats();
      req_valid <= 1'b0;
      while (lcd_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_backlight(input logic value);
      drain_beats();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      shadow_backlight  = value;
   endtask

   task automatic run_random_phase(input int s_pct, input int r_pct, input bit with_hold);
      req_idle_pct = s_pct;
      rsp_idle_pct = r_pct;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (with_hold && i == RANDOM_PER_PHASE / 3) begin
            hold_requests++;
         end
         send_beat(random_item(40), 1'b0, '0);
      end
   endtask

   task automatic report_mismatch(input string what, input clnrs_pkg::rsp_type want,
                                  input clnrs_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s: expected byte %h end %b count %0d, got byte %h end %b count %0d",
                  what, want.expander_byte, want.frame_end, want.frame_count,
                  got.expander_byte, got.frame_end, got.frame_count);
      end
   endtask

   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      clnrs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lcd_expect_q.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_payload);
         end else begin
            want = lcd_expect_q.pop_front();
            if (rsp_payload.expander_byte !== want.expander_byte ||
                rsp_payload.frame_end !== want.frame_end ||
                rsp_payload.frame_count !== want.frame_count) begin
               report_mismatch("beat mismatch", want, rsp_payload);
            end
         end
      end
   end

   initial begin : stimulus
      foreach (shadow_text[i]) begin
         shadow_text[i] = clnrs_pkg::SPACE_CHAR;
      end

      // The first frame starts with the row 0 set-address command, 0x80.
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h80, 1'b0, 8'd1}});
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h84, 1'b0, 8'd1}});
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h80, 1'b0, 8'd1}});
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h00, 1'b0, 8'd1}});
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h04, 1'b0, 8'd1}});
      directed_rows.push_back('{fetch_item(), 1'b1, '{8'h00, 1'b0, 8'd1}});
      directed_rows.push_back('{write_item(1'b0, 4'd0, 8'h00), 1'b0, '0});
      directed_rows.push_back('{write_item(1'b1, 4'd15, 8'hFF), 1'b0, '0});
      directed_rows.push_back('{write_item(1'b0, 4'd1, 8'hA5), 1'b0, '0});
      directed_rows.push_back('{write_item(1'b0, 4'd2, 8'h5A), 1'b0, '0});
      for (int i = 0; i < 12; i++) begin
         directed_rows.push_back('{fetch_item(), 1'b0, '0});
      end
      // This write lands on the position being sent next.
      directed_rows.push_back('{write_item(1'b0, 4'd2, 8'hFF), 1'b0, '0});
      directed_rows.push_back('{fetch_item(), 1'b0, '0});
      directed_rows.push_back('{fetch_item(), 1'b0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      set_backlight(1'b1);
      run_random_phase(6, 47, 1'b1);
      set_backlight(1'b0);
      run_random_phase(47, 6, 1'b0);
      set_backlight(1'b1);
      run_random_phase(0, 0, 1'b0);

      drain_beats();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/clnrs_pkg.sv
hdl/clnrs_ram.sv
hdl/char_lcd_nibble_refresh_serializer_unit.sv
tb/tb.sv
